@@ src/q16fx_pkg.sv @@
`timescale 1ns / 1ps

package q16fx_pkg;

	// Data path width and the fixed shifts of the Q16.16 format
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned HALF_SHIFT = 8;

	// One restoring step per cell, one cell per quotient bit
	localparam int unsigned DIV_CELLS = DATA_W;

	typedef enum logic [3:0] {
		OP_ADDF     = 4'd0,
		OP_ADDI     = 4'd1,
		OP_SUBF     = 4'd2,
		OP_SUBI     = 4'd3,
		OP_MULF     = 4'd4,
		OP_MULI     = 4'd5,
		OP_DIVF     = 4'd6,
		OP_DIVI     = 4'd7,
		OP_FROM_INT = 4'd8,
		OP_TO_SHORT = 4'd9
	} op_t;

	// Per-transaction side data that rides along the divider chain
	typedef struct packed {
		logic              is_div;
		logic              neg;
		logic              shf8;
		logic              dz;
		logic [DATA_W-1:0] res;
	} side_t;

	// Contents of one divider cell
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] dsr;
		side_t             side;
	} stage_t;

endpackage

@@ src/q16fx_in_if.sv @@
`timescale 1ns / 1ps

interface q16fx_in_if import q16fx_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [3:0]               opcode;
	logic signed [DATA_W-1:0] operand_a;
	logic signed [DATA_W-1:0] operand_b;

	modport source (output valid, output opcode, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input opcode, input operand_a, input operand_b,
		output ready);
endinterface

@@ src/q16fx_out_if.sv @@
`timescale 1ns / 1ps

interface q16fx_out_if import q16fx_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result;
	logic                     divide_by_zero;

	modport source (output valid, output result, output divide_by_zero, input ready);
	modport sink (input valid, input result, input divide_by_zero, output ready);
endinterface

@@ src/q16fx_prep.sv @@
`timescale 1ns / 1ps

module q16fx_prep import q16fx_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid,
	input  logic [3:0]               opcode,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output stage_t                   data
);

	logic signed [DATA_W-1:0] mul_x;
	logic signed [DATA_W-1:0] mul_y;
	logic        [DATA_W-1:0] prod;
	logic signed [DATA_W-1:0] dsr_s;
	logic        [DATA_W-1:0] abs_a;
	logic        [DATA_W-1:0] abs_d;
	logic        [DATA_W-1:0] res;
	logic                     is_div;
	stage_t                   data_s1;

	// Shared multiplier; fixed multiply pre-shifts both operands
	always_comb begin
		if (opcode == OP_MULF) begin
			mul_x = operand_a >>> HALF_SHIFT;
			mul_y = operand_b >>> HALF_SHIFT;
		end else begin
			mul_x = operand_a;
			mul_y = operand_b;
		end
	end
	assign prod = DATA_W'(mul_x * mul_y);

	// Divider operands as magnitudes, sign of the quotient kept aside
	assign dsr_s  = (opcode == OP_DIVF) ? (operand_b >>> HALF_SHIFT) : operand_b;
	assign is_div = (opcode == OP_DIVF) || (opcode == OP_DIVI);
	assign abs_a  = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : operand_a;
	assign abs_d  = dsr_s[DATA_W-1] ? DATA_W'(-dsr_s) : dsr_s;

	// Results of the non-divide operations
	always_comb begin
		unique case (opcode)
			OP_ADDF:     res = operand_a + operand_b;
			OP_ADDI:     res = operand_a + (operand_b << FRAC_BITS);
			OP_SUBF:     res = operand_a - operand_b;
			OP_SUBI:     res = operand_a - (operand_b << FRAC_BITS);
			OP_MULF,
			OP_MULI:     res = prod;
			OP_FROM_INT: res = operand_a << FRAC_BITS;
			OP_TO_SHORT: res = operand_a >>> FRAC_BITS;
			default:     res = '0;
		endcase
	end

	// Stage register feeding the first divider cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_s1 <= '0;
		end else if (en) begin
			data_s1.valid       <= valid;
			data_s1.rem         <= '0;
			data_s1.quo         <= abs_a;
			data_s1.dsr         <= abs_d;
			data_s1.side.is_div <= is_div;
			data_s1.side.neg    <= operand_a[DATA_W-1] ^ dsr_s[DATA_W-1];
			data_s1.side.shf8   <= (opcode == OP_DIVF);
			data_s1.side.dz     <= is_div && (dsr_s == '0);
			data_s1.side.res    <= res;
		end
	end

	assign data = data_s1;

endmodule

@@ src/q16fx_div_cell.sv @@
`timescale 1ns / 1ps

module q16fx_div_cell import q16fx_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  stage_t din,
	output stage_t dout
);

	logic [DATA_W:0]   trial;
	logic [DATA_W-1:0] diff;
	logic              ge;
	logic [DATA_W-1:0] rem_nxt;
	stage_t            data_s1;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial   = {din.rem, din.quo[DATA_W-1]};
	assign diff    = trial[DATA_W-1:0] - din.dsr;
	assign ge      = (trial >= {1'b0, din.dsr});
	assign rem_nxt = ge ? diff : trial[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_s1 <= '0;
		end else if (en) begin
			data_s1.valid <= din.valid;
			data_s1.rem   <= rem_nxt;
			data_s1.quo   <= {din.quo[DATA_W-2:0], ge};
			data_s1.dsr   <= din.dsr;
			data_s1.side  <= din.side;
		end
	end

	assign dout = data_s1;

endmodule

@@ src/q16fx_post.sv @@
`timescale 1ns / 1ps

module q16fx_post import q16fx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  stage_t            din,
	output logic              valid,
	output logic [DATA_W-1:0] result,
	output logic              divide_by_zero
);

	logic [DATA_W-1:0] q_signed;
	logic [DATA_W-1:0] q_final;
	logic [DATA_W-1:0] res_nxt;
	logic              valid_q;
	logic [DATA_W-1:0] result_q;
	logic              dz_q;

	// Apply quotient sign, then the fixed divide rescale
	assign q_signed = din.side.neg ? DATA_W'(-din.quo) : din.quo;
	assign q_final  = din.side.shf8 ? (q_signed << HALF_SHIFT) : q_signed;

	always_comb begin
		priority if (din.side.dz) begin
			res_nxt = '0;
		end else if (din.side.is_div) begin
			res_nxt = q_final;
		end else begin
			res_nxt = din.side.res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_nxt;
			dz_q     <= din.side.dz;
		end
	end

	assign valid          = valid_q;
	assign result         = result_q;
	assign divide_by_zero = dz_q;

endmodule

@@ src/q16_16_fixed_point_alu_core.sv @@
`timescale 1ns / 1ps

// Signed Q16.16 fixed-point ALU.
// req carries one transaction per operation: opcode, operand_a, operand_b.
// rsp returns one transaction per request, in order: result and
// divide_by_zero. Both channels use valid/ready; a transaction moves on a
// rising edge with valid and ready both high.
// Every opcode passes the same path from request to response: one
// decode/multiply stage, 32 divider cells (one quotient bit each) and the
// output register. Throughput is one transaction per cycle while rsp
// does not stall; the chain of divider cells sets the depth, and all
// opcodes travel through it so order is kept without reordering logic.
// When rsp stalls with a result waiting, the whole pipeline holds and
// req.ready drops; it rises again in the cycle the result is taken.
// Reset clears all valid bits; the block takes requests from the first
// cycle after reset. A zero divisor gives result 0 with divide_by_zero set.
module q16_16_fixed_point_alu_core import q16fx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	q16fx_in_if.sink  req,
	q16fx_out_if.source rsp
);

	logic   adv;
	logic   rsp_valid;
	stage_t chain [DIV_CELLS+1];

	// Whole pipeline advances unless a finished result is stuck at the output
	assign adv       = !rsp_valid || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = rsp_valid;

	q16fx_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid     (req.valid),
		.opcode    (req.opcode),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.data      (chain[0])
	);

	// Divider chain
	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		q16fx_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	q16fx_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (adv),
		.din            (chain[DIV_CELLS]),
		.valid          (rsp_valid),
		.result         (rsp.result),
		.divide_by_zero (rsp.divide_by_zero)
	);

endmodule
